@@ hw/rtl/uart8_pkg.sv @@
// Shared types and register indexes for the 8N1 serial transceiver with receive FIFO.
// Used by uart8_fifo and uart_8n1_with_rx_fifo; no dependencies.
package uart8_pkg;

  // Width of the reported FIFO count field
  localparam int unsigned CountW = 6;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_BIT_PERIOD  = 2'd0,
    REG_HALF_PERIOD = 2'd1,
    REG_LINE_INVERT = 2'd2,
    REG_RX_ENABLE   = 2'd3
  } reg_idx_e;

  // One tick's worth of requests toward the receive FIFO
  typedef struct packed {
    logic       step;      // a tick is being processed this cycle
    logic       pop;       // drop the head byte if not empty
    logic       flush;     // empty the FIFO
    logic       push;      // receiver delivers a byte
    logic [7:0] data;      // byte delivered by the receiver
  } fifo_req_t;

  // FIFO status after the last processed tick (registered)
  typedef struct packed {
    logic [7:0]        head_byte;
    logic              head_valid;
    logic [CountW-1:0] count;
    logic              overflow;
  } fifo_stat_t;

endpackage

@@ hw/rtl/uart_8n1_with_rx_fifo.sv @@
// 8N1 serial transceiver top: APB config registers, bit-timing sequencers,
// result pipeline. Depends on uart8_pkg and uart8_fifo.
// Throughput: one tick per clock; s_axis_tready falls only when both result
// stages are full and the master side stalls.
// A result passes through stage P (alongside the FIFO head read) and output stage O.
// Reset: sequencers idle, FIFO empty, overflow clear, registers at defaults;
// the FIFO memory needs no clearing pass.
module uart_8n1_with_rx_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick input: [0] rx_line, [1] tx_start, [9:2] tx_byte, [10] pop_req, [11] flush
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // result: [0] tx_line, [1] tx_busy, [9:2] head_byte, [10] head_valid,
  //         [16:11] fifo_count, [17] overflow
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // frame phases, shared by receiver and transmitter
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_START = 4'd1;
  localparam logic [3:0] PH_D0    = 4'd2;
  localparam logic [3:0] PH_D7    = 4'd9;
  localparam logic [3:0] PH_STOP  = 4'd10;

  logic [15:0] bit_period_q, half_period_q, period;
  logic        inv_q, rx_en_q;
  logic        cfg_wr;

  logic        step;
  logic        rx_line, tx_start, pop_req, flush;
  logic [7:0]  tx_byte;

  logic [3:0]  rx_phase_q, rx_phase_d;
  logic [15:0] rx_cnt_q, rx_cnt_d, rx_dec;
  logic [7:0]  rx_shift_q, rx_shift_d;
  logic        rx_push;

  logic [3:0]  tx_phase_q, tx_phase_d, tx_ph;
  logic [15:0] tx_cnt_q, tx_cnt_d, tx_dec;
  logic [7:0]  tx_shift_q, tx_shift_d;
  logic        tx_busy, tx_level;

  uart8_pkg::fifo_req_t  fifo_req;
  uart8_pkg::fifo_stat_t fifo_stat;

  logic        p_valid_q, p_tx_line_q, p_tx_busy_q, p_move;
  logic        o_valid_q;
  logic [23:0] o_data_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  <= 16'd868;
      half_period_q <= 16'd434;
      inv_q         <= 1'b0;
      rx_en_q       <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        uart8_pkg::REG_BIT_PERIOD:  bit_period_q  <= pwdata[15:0];
        uart8_pkg::REG_HALF_PERIOD: half_period_q <= pwdata[15:0];
        uart8_pkg::REG_LINE_INVERT: inv_q         <= pwdata[0];
        uart8_pkg::REG_RX_ENABLE:   rx_en_q       <= pwdata[0];
        default:                    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      uart8_pkg::REG_BIT_PERIOD:  prdata = {16'h0000, bit_period_q};
      uart8_pkg::REG_HALF_PERIOD: prdata = {16'h0000, half_period_q};
      uart8_pkg::REG_LINE_INVERT: prdata = {31'h0, inv_q};
      uart8_pkg::REG_RX_ENABLE:   prdata = {31'h0, rx_en_q};
      default:                    prdata = '0;
    endcase
  end

  // zero period behaves as one tick
  assign period = (bit_period_q == 16'd0) ? 16'd1 : bit_period_q;

  // ---------------- input beat ----------------
  assign p_move        = p_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !p_valid_q || p_move;
  assign step          = s_axis_tvalid && s_axis_tready;

  assign rx_line  = s_axis_tdata[0];
  assign tx_start = s_axis_tdata[1];
  assign tx_byte  = s_axis_tdata[9:2];
  assign pop_req  = s_axis_tdata[10];
  assign flush    = s_axis_tdata[11];

  // ---------------- receiver sequencer ----------------
  always_comb begin
    rx_phase_d = rx_phase_q;
    rx_cnt_d   = rx_cnt_q;
    rx_shift_d = rx_shift_q;
    rx_push    = 1'b0;
    rx_dec     = (rx_cnt_q != 16'd0) ? rx_cnt_q - 16'd1 : 16'd0;
    if (rx_phase_q == PH_IDLE) begin
      if (rx_en_q && (rx_line == inv_q)) begin
        rx_shift_d = 8'h00;
        if (half_period_q == 16'd0) begin
          rx_phase_d = PH_D0;
          rx_cnt_d   = period;
        end else begin
          rx_phase_d = PH_START;
          rx_cnt_d   = half_period_q;
        end
      end
    end else begin
      rx_cnt_d = rx_dec;
      if (rx_dec == 16'd0) begin
        unique case (rx_phase_q) inside
          PH_START: begin
            rx_phase_d = PH_D0;
            rx_cnt_d   = period;
          end
          [PH_D0:PH_D7]: begin
            rx_shift_d = {rx_line, rx_shift_q[7:1]};
            rx_phase_d = rx_phase_q + 4'd1;
            rx_cnt_d   = period;
          end
          default: begin
            rx_push    = 1'b1;
            rx_phase_d = PH_IDLE;
            rx_cnt_d   = 16'd0;
          end
        endcase
      end
    end
  end

  // ---------------- transmitter sequencer ----------------
  always_comb begin
    tx_ph      = tx_phase_q;
    tx_shift_d = tx_shift_q;
    tx_cnt_d   = tx_cnt_q;
    if ((tx_phase_q == PH_IDLE) && tx_start) begin
      tx_ph      = PH_START;
      tx_shift_d = tx_byte;
      tx_cnt_d   = period;
    end
    tx_busy = (tx_ph != PH_IDLE);
    unique case (tx_ph) inside
      PH_START:      tx_level = 1'b0;
      [PH_D0:PH_D7]: tx_level = tx_shift_d[0];
      default:       tx_level = 1'b1;
    endcase
    tx_dec     = (tx_cnt_d != 16'd0) ? tx_cnt_d - 16'd1 : 16'd0;
    tx_phase_d = tx_ph;
    if (tx_busy) begin
      tx_cnt_d = tx_dec;
      if (tx_dec == 16'd0) begin
        if ((tx_ph >= PH_D0) && (tx_ph <= PH_D7)) begin
          tx_shift_d = {1'b0, tx_shift_d[7:1]};
        end
        tx_phase_d = (tx_ph == PH_STOP) ? PH_IDLE : tx_ph + 4'd1;
        tx_cnt_d   = (tx_phase_d != PH_IDLE) ? period : 16'd0;
      end
    end
  end

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase_q <= PH_IDLE;
      rx_cnt_q   <= '0;
      rx_shift_q <= '0;
      tx_phase_q <= PH_IDLE;
      tx_cnt_q   <= '0;
      tx_shift_q <= '0;
    end else if (step) begin
      rx_phase_q <= rx_phase_d;
      rx_cnt_q   <= rx_cnt_d;
      rx_shift_q <= rx_shift_d;
      tx_phase_q <= tx_phase_d;
      tx_cnt_q   <= tx_cnt_d;
      tx_shift_q <= tx_shift_d;
    end
  end

  // ---------------- receive FIFO ----------------
  always_comb begin
    fifo_req.step  = step;
    fifo_req.pop   = step && pop_req;
    fifo_req.flush = step && flush;
    fifo_req.push  = rx_push;
    fifo_req.data  = inv_q ? ~rx_shift_q : rx_shift_q;
  end

  uart8_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .stat_o (fifo_stat)
  );

  // ---------------- result pipeline ----------------
  // stage P: line bits plus FIFO status registered alongside the head read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (step) begin
      p_valid_q <= 1'b1;
    end else if (p_move) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      p_tx_line_q <= tx_level ^ inv_q;
      p_tx_busy_q <= tx_busy;
    end
  end

  // stage O: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (p_move) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      o_data_q <= {6'h00, fifo_stat.overflow, fifo_stat.count, fifo_stat.head_valid,
                   fifo_stat.head_byte, p_tx_busy_q, p_tx_line_q};
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;

`ifndef SYNTHESIS
  a_beat_reaches_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> p_valid_q) else $error("accepted tick lost before result stage");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_phase_q <= PH_STOP) && (tx_phase_q <= PH_STOP))
    else $error("sequencer phase out of range");
  a_idle_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (tx_phase_q == PH_IDLE) && !tx_start) |=> !p_tx_busy_q)
    else $error("transmitter busy without start");
`endif

endmodule

@@ hw/rtl/uart8_fifo.sv @@
// Receive ring FIFO: synchronous byte memory, head/tail pointers and sticky overflow.
// Depends on uart8_pkg for the request and status structs.
module uart8_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  uart8_pkg::fifo_req_t  req_i,
  output uart8_pkg::fifo_stat_t stat_o
);

  localparam int unsigned AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned EXT_W = CW + uart8_pkg::CountW;
  localparam logic [AW-1:0] LAST   = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] DEPTHC = CW'(FIFO_DEPTH);

  logic [7:0]    mem_q [FIFO_DEPTH];
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] tail_mid, tail_nxt, head_nxt;
  logic          push_ok, fwd;
  logic          ovf_q, ovf_d;
  logic          hv_q;
  logic [7:0]    rd_q;
  logic [CW-1:0] diff, cnt;
  logic [EXT_W-1:0] cnt_ext;
  logic [uart8_pkg::CountW-1:0] count_q;

  // pop / flush first, then the receiver's push
  always_comb begin
    head_nxt = (head_q == LAST) ? '0 : head_q + AW'(1);
    if (req_i.flush) begin
      head_d   = '0;
      tail_mid = '0;
    end else if (req_i.pop && (head_q != tail_q)) begin
      head_d   = head_nxt;
      tail_mid = tail_q;
    end else begin
      head_d   = head_q;
      tail_mid = tail_q;
    end
    tail_nxt = (tail_mid == LAST) ? '0 : tail_mid + AW'(1);
    push_ok  = req_i.step && req_i.push && (tail_nxt != head_d);
    tail_d   = push_ok ? tail_nxt : tail_mid;
    ovf_d    = ovf_q | (req_i.step && req_i.push && (tail_nxt == head_d));
    fwd      = push_ok && (tail_mid == head_d);
  end

  // occupancy after this tick, masked to the port width
  always_comb begin
    diff    = {1'b0, tail_d} - {1'b0, head_d};
    cnt     = (tail_d >= head_d) ? diff : diff + DEPTHC;
    cnt_ext = EXT_W'(cnt);
  end

  // pointer and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      ovf_q   <= 1'b0;
      hv_q    <= 1'b0;
      count_q <= '0;
    end else if (req_i.step) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      ovf_q   <= ovf_d;
      hv_q    <= (head_d != tail_d);
      count_q <= cnt_ext[uart8_pkg::CountW-1:0];
    end
  end

  // byte memory write port
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[tail_mid] <= req_i.data;
    end
  end

  // registered head read, with bypass when the push lands on the head entry
  always_ff @(posedge clk_i) begin
    if (req_i.step) begin
      rd_q <= fwd ? req_i.data : mem_q[head_d];
    end
  end

  assign stat_o.head_byte  = hv_q ? rd_q : 8'h00;
  assign stat_o.head_valid = hv_q;
  assign stat_o.count      = count_q;
  assign stat_o.overflow   = ovf_q;

`ifndef SYNTHESIS
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q) else $error("overflow flag cleared");
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.step && req_i.flush && !req_i.push) |=> !hv_q)
    else $error("FIFO not empty after flush");
  a_full_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.step && req_i.push && !push_ok) |=> (tail_q == $past(tail_mid)))
    else $error("tail moved on dropped byte");
`endif

endmodule
